// ----- rtl/bas_pkg.sv -----
// bas_pkg: shared constants and types of the bucketed address set
// no dependencies; used by bas_bucket_div and bucketed_address_set

package bas_pkg;

    localparam int ADDR_W = 32;
    localparam int CMD_W  = 2;

    // command codes of the input word
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    // sequencer states of the top level
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CLR  = 6'b000010,
        S_DIV  = 6'b000100,
        S_FCHK = 6'b001000,
        S_SCAN = 6'b010000,
        S_RESP = 6'b100000
    } t_state;

endpackage

// ----- rtl/bas_bucket_div.sv -----
// bas_bucket_div: bucket index of an address, address mod BUCKETS
// depends on bas_pkg; a mask for a power of two, otherwise a reciprocal multiply

module bas_bucket_div #(
    parameter int BUCKETS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bas_pkg::ADDR_W-1:0]    i_addr,
    output logic                          o_done,
    output logic [$clog2(BUCKETS)-1:0]    o_bucket
);

    localparam int  BW      = $clog2(BUCKETS);
    localparam bit  IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
    localparam int  AW      = bas_pkg::ADDR_W;

    if (IS_POW2) begin : g_mask
        logic          r_done;
        logic [BW-1:0] r_rem;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_done <= 1'b0;
            end else begin
                r_done <= i_start;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_rem <= i_addr[BW-1:0];
            end
        end

        assign o_done   = r_done;
        assign o_bucket = r_rem;
    end else begin : g_recip
        // floor(2^32 / BUCKETS): the quotient estimate is exact or one short
        localparam logic [63:0]   TWO_32     = 64'h1_0000_0000;
        localparam logic [63:0]   RECIP_FULL = TWO_32 / 64'(BUCKETS);
        localparam logic [AW-1:0] RECIP      = RECIP_FULL[AW-1:0];
        localparam logic [AW-1:0] DIV_A      = AW'(BUCKETS);
        localparam logic [BW:0]   DIVISOR    = (BW + 1)'(BUCKETS);

        logic          r_v1, r_v2, r_done;
        logic [AW-1:0] r_addr;
        logic [AW-1:0] r_q;
        logic [BW:0]   r_rest;
        logic [BW-1:0] r_rem;
        logic [63:0]   prod;
        logic [AW-1:0] qb;
        logic [AW-1:0] diff;
        logic [BW:0]   rest_sub;

        assign prod     = 64'(i_addr) * 64'(RECIP);
        assign qb       = r_q * DIV_A;
        // remainder estimate lies below twice the divisor
        assign diff     = r_addr - qb;
        assign rest_sub = r_rest - DIVISOR;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v1   <= 1'b0;
                r_v2   <= 1'b0;
                r_done <= 1'b0;
            end else begin
                r_v1   <= i_start;
                r_v2   <= r_v1;
                r_done <= r_v2;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_addr <= i_addr;
                r_q    <= prod[63:32];
            end
            if (r_v1) begin
                r_rest <= diff[BW:0];
            end
            if (r_v2) begin
                r_rem <= (r_rest >= DIVISOR) ? rest_sub[BW-1:0] : r_rest[BW-1:0];
            end
        end

        assign o_done   = r_done;
        assign o_bucket = r_rem;
    end

endmodule

// ----- rtl/bucketed_address_set.sv -----
// bucketed_address_set: append-only set of 32-bit addresses in buckets
// depends on bas_pkg and bas_bucket_div; holds the slot and fill memories
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_command, i_ip_address
//  out     | output    | o_out_valid / i_out_stall  | o_found, o_dropped
//
// one word at a time; clear sweeps every entry of the fill memory
// insert writes at most one slot, lookup reads the filled slots of its bucket until a hit;
// the reciprocal bucket divider (BUCKETS not a power of two) has more registers than the mask
// lookup is bound by the slot memory read port, one stored slot per cycle
// after reset a clearing pass zeroes the fill memory
// a new word is taken while a result waits in the output register

module bucketed_address_set #(
    parameter int BUCKETS      = 32,
    parameter int BUCKET_DEPTH = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [bas_pkg::CMD_W-1:0]          i_command,
    input  logic [bas_pkg::ADDR_W-1:0]         i_ip_address,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_found,
    output logic                               o_dropped
);

    localparam int BW    = $clog2(BUCKETS);
    localparam int FW    = $clog2(BUCKET_DEPTH + 1);
    localparam int SLOTS = BUCKETS * BUCKET_DEPTH;
    localparam int AW    = $clog2(SLOTS);

    localparam logic [FW-1:0] DEPTH_F = FW'(BUCKET_DEPTH);
    localparam logic [BW-1:0] LAST_B  = BW'(BUCKETS - 1);

    // sequencer and word registers
    bas_pkg::t_state              r_state, n_state;
    logic [BW-1:0]                r_clr_idx, n_clr_idx;
    logic                         r_clr_cmd, n_clr_cmd;   // sweep owes a result
    logic [bas_pkg::CMD_W-1:0]    r_cmd, n_cmd;
    logic [bas_pkg::ADDR_W-1:0]   r_addr, n_addr;
    logic [BW-1:0]                r_bucket, n_bucket;
    logic [AW-1:0]                r_base, n_base;         // first slot of the bucket
    logic [FW-1:0]                r_scan_idx, n_scan_idx;
    logic [FW-1:0]                r_scan_n, n_scan_n;
    logic                         r_pend, n_pend;         // slot read in flight
    logic                         r_res_found, n_res_found;
    logic                         r_res_dropped, n_res_dropped;

    // output register
    logic                         r_out_valid, n_out_valid;
    logic                         r_found, r_dropped;
    logic                         load_out;

    // memory ports
    logic [FW-1:0]                mem_fill [BUCKETS];
    logic                         fill_we, fill_re;
    logic [BW-1:0]                fill_waddr, fill_raddr;
    logic [FW-1:0]                fill_wdata;
    logic [FW-1:0]                r_fill_rdata;

    logic [bas_pkg::ADDR_W-1:0]   mem_store [SLOTS];
    logic                         store_we, store_re;
    logic [AW-1:0]                store_waddr, store_raddr;
    logic [bas_pkg::ADDR_W-1:0]   r_store_rdata;

    // handshakes and divider
    logic                         in_accept, out_accept;
    logic                         div_start, div_done;
    logic [BW-1:0]                div_bucket;
    logic                         scan_issue;

    assign in_accept  = i_in_valid && (r_state == bas_pkg::S_IDLE);
    assign out_accept = r_out_valid && !i_out_stall;
    assign o_in_stall = (r_state != bas_pkg::S_IDLE);

    assign div_start = in_accept &&
                       ((i_command == bas_pkg::CMD_INSERT) ||
                        (i_command == bas_pkg::CMD_LOOKUP));

    bas_bucket_div #(
        .BUCKETS (BUCKETS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_addr   (i_ip_address),
        .o_done   (div_done),
        .o_bucket (div_bucket)
    );

    assign scan_issue = (r_scan_idx < r_scan_n);

    // one word is in flight at a time, so a write and a read of the same
    // entry never fall in one cycle: no forwarding is needed
    always_comb begin
        n_state       = r_state;
        n_clr_idx     = r_clr_idx;
        n_clr_cmd     = r_clr_cmd;
        n_cmd         = r_cmd;
        n_addr        = r_addr;
        n_bucket      = r_bucket;
        n_base        = r_base;
        n_scan_idx    = r_scan_idx;
        n_scan_n      = r_scan_n;
        n_pend        = 1'b0;
        n_res_found   = r_res_found;
        n_res_dropped = r_res_dropped;
        load_out      = 1'b0;
        fill_we       = 1'b0;
        fill_waddr    = r_bucket;
        fill_wdata    = r_fill_rdata + FW'(1);
        fill_re       = 1'b0;
        fill_raddr    = div_bucket;
        store_we      = 1'b0;
        store_waddr   = r_base + AW'(r_fill_rdata);
        store_re      = 1'b0;
        store_raddr   = r_base + AW'(r_scan_idx);

        unique case (r_state)
            bas_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_cmd         = i_command;
                    n_addr        = i_ip_address;
                    n_res_found   = 1'b0;
                    n_res_dropped = 1'b0;
                    unique case (i_command) inside
                        bas_pkg::CMD_CLEAR: begin
                            n_state   = bas_pkg::S_CLR;
                            n_clr_idx = '0;
                            n_clr_cmd = 1'b1;
                        end
                        bas_pkg::CMD_INSERT, bas_pkg::CMD_LOOKUP: begin
                            n_state = bas_pkg::S_DIV;
                        end
                        default: begin
                            // unused command: empty answer
                            n_state = bas_pkg::S_RESP;
                        end
                    endcase
                end
            end
            bas_pkg::S_CLR: begin
                // zero one bucket fill per cycle
                fill_we    = 1'b1;
                fill_waddr = r_clr_idx;
                fill_wdata = '0;
                if (r_clr_idx == LAST_B) begin
                    n_state   = r_clr_cmd ? bas_pkg::S_RESP : bas_pkg::S_IDLE;
                    n_clr_cmd = 1'b0;
                end else begin
                    n_clr_idx = r_clr_idx + BW'(1);
                end
            end
            bas_pkg::S_DIV: begin
                if (div_done) begin
                    fill_re  = 1'b1;
                    n_bucket = div_bucket;
                    n_base   = AW'(div_bucket * BUCKET_DEPTH);
                    n_state  = bas_pkg::S_FCHK;
                end
            end
            bas_pkg::S_FCHK: begin
                if (r_cmd == bas_pkg::CMD_INSERT) begin
                    // a full bucket drops even the zero address
                    if (r_fill_rdata >= DEPTH_F) begin
                        n_res_dropped = 1'b1;
                    end else if (r_addr != '0) begin
                        store_we = 1'b1;
                        fill_we  = 1'b1;
                    end
                    n_state = bas_pkg::S_RESP;
                end else if ((r_addr == '0) || (r_fill_rdata == '0)) begin
                    n_state = bas_pkg::S_RESP;
                end else begin
                    n_scan_idx = '0;
                    n_scan_n   = r_fill_rdata;
                    n_state    = bas_pkg::S_SCAN;
                end
            end
            bas_pkg::S_SCAN: begin
                // read issued one cycle, compared the next
                if (r_pend && (r_store_rdata == r_addr)) begin
                    n_res_found = 1'b1;
                    n_state     = bas_pkg::S_RESP;
                end else if (!scan_issue && !r_pend) begin
                    n_state = bas_pkg::S_RESP;
                end else if (scan_issue) begin
                    store_re   = 1'b1;
                    n_scan_idx = r_scan_idx + FW'(1);
                    n_pend     = 1'b1;
                end
            end
            bas_pkg::S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = bas_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bas_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (out_accept) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control registers; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bas_pkg::S_CLR;
            r_clr_idx   <= '0;
            r_clr_cmd   <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_clr_cmd   <= n_clr_cmd;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_addr        <= n_addr;
        r_bucket      <= n_bucket;
        r_base        <= n_base;
        r_scan_idx    <= n_scan_idx;
        r_scan_n      <= n_scan_n;
        r_res_found   <= n_res_found;
        r_res_dropped <= n_res_dropped;
        if (load_out) begin
            r_found   <= r_res_found;
            r_dropped <= r_res_dropped;
        end
    end

    // fill count memory
    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            mem_fill[fill_waddr] <= fill_wdata;
        end
        if (fill_re) begin
            r_fill_rdata <= mem_fill[fill_raddr];
        end
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            mem_store[store_waddr] <= r_addr;
        end
        if (store_re) begin
            r_store_rdata <= mem_store[store_raddr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_dropped   = r_dropped;

`ifndef SYNTHESIS
    a_scan_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bas_pkg::S_SCAN) |-> (r_scan_idx <= r_scan_n))
        else $error("scan index ran past the bucket fill");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bas_pkg::S_FCHK) |-> (r_fill_rdata <= DEPTH_F))
        else $error("bucket fill above depth");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == bas_pkg::S_RESP))
        else $error("result shown without a finished word");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_found && o_dropped))
        else $error("found and dropped both set");
`endif

endmodule

// ----- tb/tb_bucketed_address_set.sv -----
// tb_bucketed_address_set: self-checking bench for the bucketed address set
// depends on bas_pkg and bucketed_address_set; a scoreboard class predicts found and dropped
// runs directed corner words, then clear-led rounds that fill buckets and probe them

module tb_bucketed_address_set;

    localparam int BUCKETS      = 32;
    localparam int BUCKET_DEPTH = 256;

    // command code left unused by the block, answered with an all-zero result
    localparam logic [bas_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int N_RANDOM    = 1450;
    localparam int CYCLE_LIMIT = 3_000_000;
    // a full-bucket lookup scans every slot of the bucket
    localparam int DRAIN       = BUCKET_DEPTH + 64;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic found;
        logic dropped;
    } t_outcome;

    // predictor of the address table plus the queue of outcomes still owed
    class address_set_scoreboard;
        logic [bas_pkg::ADDR_W-1:0] slot_mem [BUCKETS*BUCKET_DEPTH];
        int unsigned                fill [BUCKETS];
        t_outcome                   outcome_q [$];
        int unsigned       n_err, n_insert, n_drop, n_lookup, n_hit, n_clear, n_unused;

        function new();
            foreach (fill[k]) fill[k] = 0;
            n_err = 0; n_insert = 0; n_drop = 0; n_lookup = 0;
            n_hit = 0; n_clear = 0; n_unused = 0;
        endfunction

        function void note_word(logic [bas_pkg::CMD_W-1:0] cmd,
                                logic [bas_pkg::ADDR_W-1:0] addr);
            t_outcome    res;
            int unsigned bkt;
            res = '0;
            bkt = addr % BUCKETS;
            case (cmd)
                bas_pkg::CMD_CLEAR: begin
                    foreach (fill[k]) fill[k] = 0;
                    n_clear++;
                end
                bas_pkg::CMD_INSERT: begin
                    n_insert++;
                    if (fill[bkt] >= BUCKET_DEPTH) begin
                        res.dropped = 1'b1;
                        n_drop++;
                    end else if (addr != '0) begin
                        slot_mem[bkt*BUCKET_DEPTH + fill[bkt]] = addr;
                        fill[bkt]++;
                    end
                end
                bas_pkg::CMD_LOOKUP: begin
                    n_lookup++;
                    if (addr != '0) begin
                        for (int i = 0; i < fill[bkt]; i++)
                            if (slot_mem[bkt*BUCKET_DEPTH + i] == addr) res.found = 1'b1;
                    end
                    if (res.found) n_hit++;
                end
                default: n_unused++;
            endcase
            outcome_q.push_back(res);
        endfunction

        function void check_result(logic found, logic dropped);
            t_outcome exp_r;
            if (outcome_q.size() == 0) begin
                $error("result with no word pending: found=%0b dropped=%0b", found, dropped);
                n_err++;
                return;
            end
            exp_r = outcome_q.pop_front();
            if (found !== exp_r.found) begin
                $error("found: expected %0b, got %0b", exp_r.found, found);
                n_err++;
            end
            if (dropped !== exp_r.dropped) begin
                $error("dropped: expected %0b, got %0b", exp_r.dropped, dropped);
                n_err++;
            end
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [bas_pkg::CMD_W-1:0]  i_command = bas_pkg::CMD_CLEAR;
    logic [bas_pkg::ADDR_W-1:0] i_ip_address = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic                       o_found;
    logic                       o_dropped;

    address_set_scoreboard sb = new();

    // addresses already inserted, reused for hits and for duplicate inserts
    logic [bas_pkg::ADDR_W-1:0] addr_pool [$];
    // set for a stretch of the random part: neither side idles
    logic              no_idle = 1'b0;
    int                random_sent = 0;
    int                fill_rounds = 0;
    int unsigned       cycle_count = 0;

    bucketed_address_set #(
        .BUCKETS      (BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_ip_address (i_ip_address),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_found      (o_found),
        .o_dropped    (o_dropped)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_bucketed_address_set: errors");
            $finish;
        end
    end

    // receive side: check every accepted result, stall at random,
    // and twice hold off for a long stretch so the block backs up into its input
    int results_seen   = 0;
    int hold_left      = 0;
    int next_hold_mark = 200;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_found, o_dropped);
            results_seen++;
        end
        if (hold_left == 0 && next_hold_mark <= 900 && results_seen >= next_hold_mark) begin
            hold_left = HOLD_CYCLES;
            next_hold_mark += 700;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !no_idle && ($urandom_range(0, 99) < 9);
        end
    end

    // offer one word and wait for it to be taken; an optional gap goes first
    task automatic send_word(input logic [bas_pkg::CMD_W-1:0] cmd,
                             input logic [bas_pkg::ADDR_W-1:0] addr);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 9) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_ip_address <= addr;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(cmd, addr);
        if (cmd == bas_pkg::CMD_INSERT && addr != '0) begin
            addr_pool.push_back(addr);
            if (addr_pool.size() > 512) void'(addr_pool.pop_front());
        end
    endtask

    // random upper bits, bucket chosen by the caller
    function automatic logic [bas_pkg::ADDR_W-1:0] addr_in_bucket(int bkt);
        return ($urandom / BUCKETS) * BUCKETS + bkt;
    endfunction

    function automatic logic [bas_pkg::ADDR_W-1:0] pick_pooled(int bkt);
        if (addr_pool.size() == 0) return addr_in_bucket(bkt);
        return addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    endfunction

    // one random word aimed at a bucket; ins_pct sets the share of inserts
    task automatic random_word(input int bkt, input int ins_pct);
        int                         r;
        int                         s;
        logic [bas_pkg::ADDR_W-1:0] addr;
        r = $urandom_range(0, 99);
        s = $urandom_range(0, 99);
        if (r < ins_pct) begin
            // mostly fresh, some duplicates, a few zeros
            if (s < 5)       addr = '0;
            else if (s < 15) addr = pick_pooled(bkt);
            else             addr = addr_in_bucket(bkt);
            send_word(bas_pkg::CMD_INSERT, addr);
        end else if (r < 95) begin
            if (s < 5)       addr = '0;
            else if (s < 55) addr = pick_pooled(bkt);
            else             addr = addr_in_bucket(bkt);
            send_word(bas_pkg::CMD_LOOKUP, addr);
        end else if (r < 97) begin
            send_word(bas_pkg::CMD_INSERT, $urandom);
        end else if (r < 99) begin
            send_word(CMD_UNUSED, $urandom);
        end else begin
            send_word(bas_pkg::CMD_LOOKUP, $urandom);
        end
        random_sent++;
        // a stretch with no idling on either side
        if (random_sent == 500) no_idle <= 1'b1;
        if (random_sent == 750) no_idle <= 1'b0;
    endtask

    initial begin
        int hot;
        int hot_set [4];
        int round_len;
        int post_full;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners: empty table, extreme addresses, zero, duplicates,
        // the unused command, and lookups after a clear
        send_word(bas_pkg::CMD_LOOKUP, 32'hFFFF_FFFF);
        send_word(bas_pkg::CMD_INSERT, 32'hFFFF_FFFF);
        send_word(bas_pkg::CMD_LOOKUP, 32'hFFFF_FFFF);
        send_word(bas_pkg::CMD_INSERT, 32'h0000_0001);
        send_word(bas_pkg::CMD_INSERT, 32'h8000_0000);
        send_word(bas_pkg::CMD_LOOKUP, 32'h8000_0000);
        send_word(bas_pkg::CMD_INSERT, 32'h0000_0000);
        send_word(bas_pkg::CMD_LOOKUP, 32'h0000_0000);
        send_word(bas_pkg::CMD_INSERT, 32'hFFFF_FFFF);
        send_word(bas_pkg::CMD_LOOKUP, 32'h7FFF_FFFF);
        send_word(CMD_UNUSED,          32'hFFFF_FFFF);
        send_word(CMD_UNUSED,          32'h0000_0000);
        send_word(bas_pkg::CMD_LOOKUP, 32'h0000_0001);
        send_word(bas_pkg::CMD_CLEAR,  32'hA5A5_A5A5);
        send_word(bas_pkg::CMD_LOOKUP, 32'hFFFF_FFFF);
        send_word(bas_pkg::CMD_LOOKUP, 32'h8000_0000);
        send_word(bas_pkg::CMD_INSERT, 32'hAAAA_AAAA);
        send_word(bas_pkg::CMD_INSERT, 32'h5555_5555);
        send_word(bas_pkg::CMD_LOOKUP, 32'hAAAA_AAAA);
        send_word(bas_pkg::CMD_LOOKUP, 32'h5555_5555);
        send_word(bas_pkg::CMD_INSERT, 32'hFFFF_FFE0);
        send_word(bas_pkg::CMD_LOOKUP, 32'hFFFF_FFE0);
        send_word(bas_pkg::CMD_CLEAR,  32'h0000_0000);

        // random rounds, each opened by a clear; the first fills bucket zero
        // so that inserts of zero meet a full bucket
        while (random_sent < N_RANDOM) begin
            send_word(bas_pkg::CMD_CLEAR, $urandom);
            random_sent++;
            if (fill_rounds == 0 || $urandom_range(0, 99) < 25) begin
                hot = (fill_rounds == 0) ? 0 : $urandom_range(0, BUCKETS - 1);
                fill_rounds++;
                // insert-heavy until the bucket is full, then probe and overflow it
                while (sb.fill[hot] < BUCKET_DEPTH) random_word(hot, 85);
                post_full = $urandom_range(40, 80);
                repeat (post_full) random_word(hot, 45);
            end else begin
                foreach (hot_set[k]) hot_set[k] = $urandom_range(0, BUCKETS - 1);
                round_len = $urandom_range(40, 120);
                repeat (round_len) begin
                    if ($urandom_range(0, 99) < 3) begin
                        // stray clear inside a round
                        send_word(bas_pkg::CMD_CLEAR, $urandom);
                        random_sent++;
                    end else begin
                        random_word(hot_set[$urandom_range(0, 3)], 50);
                    end
                end
            end
        end
        i_in_valid <= 1'b0;

        // wait for every owed result, then watch for strays
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (sb.pending() > 0) begin
            $error("%0d results never arrived", sb.pending());
            sb.n_err++;
        end

        $display("run: %0d inserts with %0d drops, %0d lookups with %0d hits",
                 sb.n_insert, sb.n_drop, sb.n_lookup, sb.n_hit);
        $display("run: %0d clears, %0d unused-command words, %0d buckets filled to the top",
                 sb.n_clear, sb.n_unused, fill_rounds);
        if (sb.n_err == 0) begin
            $display("tb_bucketed_address_set: clean");
        end else begin
            $display("tb_bucketed_address_set: errors");
        end
        $finish;
    end

endmodule
